// ===== rtl/nearest_palette_color_unit_defines.svh =====
// Assertion macros for the nearest palette color unit.
// Used by the top level; needs a clock named clk and a reset named rst in scope.
`ifndef NEAREST_PALETTE_COLOR_UNIT_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property checked on every clock edge outside reset.
`define NPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Property checked on every clock edge, reset included.
`define NPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NPC_ASSERT(lbl, prop, msg)
`define NPC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/npc_pkg.sv =====
// Shared types and constants for the nearest palette color unit.
// No dependencies.
`default_nettype none

package npc_pkg;

  // Palette size and derived address width
  localparam int PALETTE_DEPTH = 256;
  localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
  // Entry number base + offset: wide enough for 255 + 255 and for any address
  localparam int SUM_W         = (ADDR_W > 9) ? ADDR_W : 9;

  // Longest row a query searches
  localparam logic [8:0] MAX_ROW = 9'd256;

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       is_reserved;
    logic [7:0] row_base;
    logic [8:0] row_count;
    logic       check_reserved;
  } in_t;

  typedef struct packed {
    logic [7:0]  best_offset;
    logic [17:0] best_distance;
    logic        found;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/nearest_palette_color_unit.sv =====
// Nearest palette color unit: top level with the palette memory and the search sequencer.
// Depends on npc_pkg and nearest_palette_color_unit_defines.svh.
//
// Usage: one input channel (in_valid/in_ready/in_data) carries two kinds of beat.
// A write beat stores one palette entry (RGB and reserved flag) and gives no
// result. A query beat scans entries base+count-1 down to base, one entry
// per cycle through a shared read / square / compare path, and returns one result
// beat (offset, squared distance, found) on out_valid/out_ready.
// A query holds in_ready low until its result is loaded into the output register,
// which is also when out_valid rises; row_count is clamped to 256.
// The single palette read port sets the pace: one entry per cycle, after which the read,
// square and compare stages drain before the result is loaded. Writes run back to back.
// A result waiting in the output register does not stop new beats; a query that
// finishes while the previous result is still stalled holds until it is taken.
// Reset clears the sequencer, the output register and all written bits. Palette
// colors are undefined until written; no clearing pass is needed.
`default_nettype none
`include "nearest_palette_color_unit_defines.svh"

module nearest_palette_color_unit
  import npc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;

  // Palette memory: {reserved, red, green, blue}; written bits say an entry holds data
  logic [24:0] palette [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] written;
  logic [24:0] rd_word;

  // Query registers
  logic [7:0] q_red, q_green, q_blue;
  logic [7:0] q_base;
  logic       q_check;
  logic [8:0] remaining;

  // Read stage
  logic       p1_valid;
  logic       p1_inrange;
  logic       p1_written;
  logic [7:0] p1_off;

  // Square stage
  logic        p2_valid;
  logic        p2_qual;
  logic [7:0]  p2_off;
  logic [15:0] sq_r, sq_g, sq_b;

  // Running best
  logic        found_q;
  logic [17:0] best_dist;
  logic [7:0]  best_off;

  // Issue side: next entry to read
  logic [8:0]       rem_m1;
  logic [7:0]       issue_off;
  logic [SUM_W-1:0] issue_entry;
  logic             issue;
  logic             issue_inrange;

  // Write side
  logic             wr_en;
  logic [ADDR_W-1:0] wr_addr;

  // Square stage inputs
  logic [7:0] dr, dg, db;
  logic       p1_qual;

  // Compare stage
  logic [17:0] dist_sum;
  logic        take;

  logic in_fire;
  logic out_load;
  logic [8:0] cnt_clamped;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  assign cnt_clamped = (in_data.row_count > MAX_ROW) ? MAX_ROW : in_data.row_count;

  assign rem_m1        = remaining - 9'd1;
  assign issue_off     = rem_m1[7:0];
  assign issue         = (state == S_SCAN) && (remaining != 9'd0);
  assign issue_entry   = SUM_W'(q_base) + SUM_W'(issue_off);
  assign issue_inrange = (32'(issue_entry) < 32'(PALETTE_DEPTH));

  assign wr_en   = in_fire && (in_data.kind == KIND_WRITE)
                   && (32'(in_data.entry_index) < 32'(PALETTE_DEPTH));
  assign wr_addr = ADDR_W'(in_data.entry_index);

  // Palette memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      palette[wr_addr] <= {in_data.is_reserved, in_data.red, in_data.green, in_data.blue};
    end
    if (issue) begin
      rd_word <= palette[issue_entry[ADDR_W-1:0]];
    end
  end

  // Written bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire && (in_data.kind == KIND_QUERY)) state <= S_SCAN;
        end
        S_SCAN: begin
          if ((remaining == 9'd0) && !p1_valid && !p2_valid) state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Query capture and issue count
  always_ff @(posedge clk) begin
    if (in_fire && (in_data.kind == KIND_QUERY)) begin
      q_red     <= in_data.red;
      q_green   <= in_data.green;
      q_blue    <= in_data.blue;
      q_base    <= in_data.row_base;
      q_check   <= in_data.check_reserved;
      remaining <= cnt_clamped;
    end else if (issue) begin
      remaining <= rem_m1;
    end
  end

  // Read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p1_inrange <= issue_inrange;
      p1_written <= written[issue_entry[ADDR_W-1:0]];
      p1_off     <= issue_off;
    end
  end

  // Square stage: absolute channel differences squared
  assign dr = (rd_word[23:16] > q_red)   ? rd_word[23:16] - q_red   : q_red   - rd_word[23:16];
  assign dg = (rd_word[15:8]  > q_green) ? rd_word[15:8]  - q_green : q_green - rd_word[15:8];
  assign db = (rd_word[7:0]   > q_blue)  ? rd_word[7:0]   - q_blue  : q_blue  - rd_word[7:0];
  assign p1_qual = p1_inrange && !(q_check && p1_written && rd_word[24]);

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_valid) begin
      p2_qual <= p1_qual;
      p2_off  <= p1_off;
      sq_r    <= dr * dr;
      sq_g    <= dg * dg;
      sq_b    <= db * db;
    end
  end

  // Compare stage: strictly smaller wins, so the higher entry keeps a tie
  assign dist_sum = 18'(sq_r) + 18'(sq_g) + 18'(sq_b);
  assign take     = p2_valid && p2_qual && (!found_q || (dist_sum < best_dist));

  always_ff @(posedge clk) begin
    if (in_fire && (in_data.kind == KIND_QUERY)) begin
      found_q   <= 1'b0;
      best_dist <= '0;
      best_off  <= '0;
    end else if (take) begin
      found_q   <= 1'b1;
      best_dist <= dist_sum;
      best_off  <= p2_off;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.best_offset   <= best_off;
      out_data.best_distance <= best_dist;
      out_data.found         <= found_q;
    end
  end

  // Checks
  `NPC_ASSERT(a_empty_result, out_valid && !out_data.found |-> (out_data.best_offset == 8'd0) && (out_data.best_distance == 18'd0), "result without a match must be all zero")
  `NPC_ASSERT(a_pipe_in_scan, p2_valid |-> (state == S_SCAN), "compare stage busy outside a scan")
  `NPC_ASSERT(a_best_falls, (state == S_SCAN) && found_q |=> best_dist <= $past(best_dist), "best distance grew during a scan")

endmodule

`default_nettype wire

// ===== tb/nearest_palette_color_unit_tb.sv =====
// Self-checking testbench for the nearest palette color unit.
// Depends on npc_pkg and the nearest_palette_color_unit top level.
`timescale 1ns / 100ps

module nearest_palette_color_unit_tb;
  import npc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  nearest_palette_color_unit dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Beats waiting to be driven, and query answers waiting to come back
  in_t  pending_beats[$];
  out_t expected_answers[$];

  // Predictor copy of the palette
  logic [23:0] pal_rgb[PALETTE_DEPTH];
  bit          pal_reserved[PALETTE_DEPTH];
  // Entries written by the stimulus so far (generation side, ahead of the DUT)
  bit          staged_written[PALETTE_DEPTH];

  int send_idle_pct = 24;
  int recv_idle_pct = 45;
  int long_stall_req = 0;
  int long_stall_seen = 0;
  int stall_left = 0;

  int items_queued = 0;
  int mismatch_count = 0;
  int writes_seen = 0;
  int queries_seen = 0;
  int answers_checked = 0;
  int hits_seen = 0;
  out_t want;

  // Nearest entry by squared RGB distance; on a tie the higher entry wins
  function automatic out_t nearest_entry(in_t q);
    out_t res;
    int span, e, dr, dg, db, d, best;
    bit hit;
    res = '0;
    hit = 1'b0;
    best = 0;
    span = (q.row_count > MAX_ROW) ? int'(MAX_ROW) : int'(q.row_count);
    for (int k = span; k > 0; k--) begin
      e = int'(q.row_base) + k - 1;
      if (e >= PALETTE_DEPTH) continue;
      if (q.check_reserved && pal_reserved[e]) continue;
      dr = int'(pal_rgb[e][23:16]) - int'(q.red);
      dg = int'(pal_rgb[e][15:8]) - int'(q.green);
      db = int'(pal_rgb[e][7:0]) - int'(q.blue);
      d = dr * dr + dg * dg + db * db;
      if (!hit || d < best) begin
        hit = 1'b1;
        best = d;
        res.best_offset = 8'(k - 1);
      end
    end
    res.best_distance = 18'(best);
    res.found = hit;
    return res;
  endfunction

  // Mostly random levels, sometimes from a tiny set so ties show up
  function automatic logic [7:0] pick_level();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // How far a row from base may reach over written entries; 256 if it runs off the end
  function automatic int row_reach(int base);
    int n;
    n = 0;
    while (base + n < PALETTE_DEPTH && staged_written[base + n]) n++;
    return (base + n == PALETTE_DEPTH) ? int'(MAX_ROW) : n;
  endfunction

  task automatic push_write(int idx, logic [7:0] r, logic [7:0] g, logic [7:0] b, bit resv);
    in_t it;
    it.kind           = KIND_WRITE;
    it.entry_index    = 8'(idx);
    it.red            = r;
    it.green          = g;
    it.blue           = b;
    it.is_reserved    = resv;
    it.row_base       = 8'($urandom_range(255));
    it.row_count      = 9'($urandom_range(256));
    it.check_reserved = 1'($urandom_range(1));
    staged_written[idx] = 1'b1;
    pending_beats.push_back(it);
    items_queued++;
  endtask

  task automatic push_query(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            int base, int cnt, bit chk);
    in_t it;
    it.kind           = KIND_QUERY;
    it.entry_index    = 8'($urandom_range(255));
    it.red            = r;
    it.green          = g;
    it.blue           = b;
    it.is_reserved    = 1'($urandom_range(1));
    it.row_base       = 8'(base);
    it.row_count      = 9'(cnt);
    it.check_reserved = chk;
    pending_beats.push_back(it);
    items_queued++;
  endtask

  // Query a row that only covers written entries; long rows are rare
  task automatic push_row_query(int base);
    int lim, cap, cnt;
    lim = row_reach(base);
    cap = ($urandom_range(19) == 0) ? int'(MAX_ROW) : 16;
    cnt = $urandom_range((lim < cap) ? lim : cap);
    if (lim == int'(MAX_ROW) && cap == int'(MAX_ROW) && $urandom_range(1)) cnt = int'(MAX_ROW);
    push_query(pick_level(), pick_level(), pick_level(), base, cnt, 1'($urandom_range(1)));
  endtask

  // Mostly a row of writes then queries into it; the rest lone writes and queries
  task automatic push_burst();
    int roll, first, len, n, qb;
    roll = $urandom_range(99);
    if (roll < 70) begin
      first = $urandom_range(255);
      len = ($urandom_range(19) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 12);
      for (int i = 0; i < len && first + i < PALETTE_DEPTH; i++)
        push_write(first + i, pick_level(), pick_level(), pick_level(),
                   $urandom_range(3) == 0);
      n = $urandom_range(1, 3);
      for (int j = 0; j < n; j++) begin
        qb = first + $urandom_range(len - 1);
        if (qb >= PALETTE_DEPTH) qb = first;
        push_row_query(qb);
      end
    end else if (roll < 85) begin
      push_write($urandom_range(255), 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 1'($urandom_range(1)));
    end else begin
      push_row_query($urandom_range(255));
    end
  endtask

  // Sampled at a falling edge so nothing is in flight at that instant
  task automatic wait_all_done();
    while (pending_beats.size() != 0 || in_valid || expected_answers.size() != 0)
      @(negedge clk);
  endtask

  // Input driver: next beat only after the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_beats.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure, with an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (long_stall_seen != long_stall_req) begin
      long_stall_seen <= long_stall_req;
      stall_left <= 400;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predict on each accepted beat, check each accepted result
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (in_data.kind == KIND_WRITE) begin
          writes_seen++;
          if (int'(in_data.entry_index) < PALETTE_DEPTH) begin
            pal_rgb[in_data.entry_index] = {in_data.red, in_data.green, in_data.blue};
            pal_reserved[in_data.entry_index] = in_data.is_reserved;
          end
        end else begin
          queries_seen++;
          expected_answers.push_back(nearest_entry(in_data));
        end
      end
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          $error("result beat with no query outstanding");
          mismatch_count++;
        end else begin
          want = expected_answers.pop_front();
          answers_checked++;
          if (want.found) hits_seen++;
          if (out_data.best_offset !== want.best_offset) begin
            $error("best_offset: expected %0d, got %0d", want.best_offset, out_data.best_offset);
            mismatch_count++;
          end
          if (out_data.best_distance !== want.best_distance) begin
            $error("best_distance: expected %0d, got %0d",
                   want.best_distance, out_data.best_distance);
            mismatch_count++;
          end
          if (out_data.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_data.found);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: color extremes, reserved skip, ties, empty rows, row past the end
    push_write(0, 8'd0, 8'd0, 8'd0, 1'b0);
    push_write(1, 8'd255, 8'd255, 8'd255, 1'b1);
    push_write(2, 8'd128, 8'd64, 8'd32, 1'b0);
    push_write(3, 8'd128, 8'd64, 8'd32, 1'b0);
    push_write(254, 8'd255, 8'd0, 8'd255, 1'b0);
    push_write(255, 8'd0, 8'd255, 8'd0, 1'b1);
    push_query(8'd255, 8'd255, 8'd255, 0, 2, 1'b1);
    push_query(8'd255, 8'd255, 8'd255, 0, 2, 1'b0);
    push_query(8'd128, 8'd64, 8'd32, 0, 4, 1'b1);
    push_query(8'd10, 8'd20, 8'd30, 1, 1, 1'b1);
    push_query(8'd10, 8'd20, 8'd30, 0, 0, 1'b0);
    push_query(8'd0, 8'd255, 8'd0, 254, 256, 1'b0);
    push_query(8'd0, 8'd255, 8'd0, 254, 256, 1'b1);
    push_query(8'd0, 8'd255, 8'd0, 255, 256, 1'b1);
    push_query(8'd255, 8'd255, 8'd255, 0, 1, 1'b0);

    // Sender idles more lightly than the receiver
    while (items_queued < 265) push_burst();
    wait_all_done();

    // Roles swapped
    send_idle_pct = 45;
    recv_idle_pct = 24;
    while (items_queued < 505) push_burst();
    wait_all_done();

    // No idling; a long receiver hold-off lets the block back up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_stall_req = long_stall_req + 1;
    while (items_queued < 750) push_burst();
    wait_all_done();

    repeat (300) @(posedge clk);
    if (expected_answers.size() != 0) begin
      $error("%0d query results never arrived", expected_answers.size());
      mismatch_count += expected_answers.size();
    end
    $display("Drove %0d palette writes and %0d queries over three back-pressure phases,",
             writes_seen, queries_seen);
    $display("checked %0d results, %0d of them with a qualifying entry.",
             answers_checked, hits_seen);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit: far beyond the slowest legal run
  initial begin
    #18_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/npc_pkg.sv
rtl/nearest_palette_color_unit.sv
tb/nearest_palette_color_unit_tb.sv
